@@ rtl/rau_pkg.sv @@
// rau_pkg: types, codes and helpers for the rational arithmetic unit
// no dependencies; imported by rational_arithmetic_unit, rau_checker and the testbench

package rau_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int NUM_W       = 64;
    localparam int DEN_W       = 63;
    localparam int CNT_W       = $clog2(NUM_W);

    localparam logic [NUM_W-1:0] MAXPOS = (NUM_W'(1) << (VALUE_WIDTH - 1)) - NUM_W'(1);

    localparam logic [2:0] FN_ADD   = 3'd0;
    localparam logic [2:0] FN_SUB   = 3'd1;
    localparam logic [2:0] FN_MUL   = 3'd2;
    localparam logic [2:0] FN_DIV   = 3'd3;
    localparam logic [2:0] FN_CMP   = 3'd4;
    localparam logic [2:0] FN_NORM  = 3'd5;
    localparam logic [2:0] FN_TRUNC = 3'd6;
    localparam logic [2:0] FN_NONE  = 3'd7;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_OVF     = 2'd1;
    localparam logic [1:0] ERR_DIVZERO = 2'd2;
    localparam logic [1:0] ERR_ZERODEN = 2'd3;

    localparam logic [1:0] DM_TRUNC = 2'd0;
    localparam logic [1:0] DM_NUM   = 2'd1;
    localparam logic [1:0] DM_DEN   = 2'd2;

    typedef struct packed {
        logic [2:0]              func;
        logic signed [NUM_W-1:0] a_num;
        logic [DEN_W-1:0]        a_den;
        logic signed [NUM_W-1:0] b_num;
        logic [DEN_W-1:0]        b_den;
    } op_word_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    is_less;
        logic                    is_equal;
        logic                    is_greater;
        logic [1:0]              error_code;
    } res_word_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_EVAL = 7'b0000100,
        ST_GCD  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    // signed magnitude value fits the signed range
    function automatic logic fits(input logic neg, input logic [NUM_W-1:0] hi,
                                  input logic [NUM_W-1:0] lo);
        logic [NUM_W-1:0] lim;
        lim  = MAXPOS + NUM_W'(neg);
        fits = (hi == '0) && (lo <= lim);
    endfunction

endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// rational_arithmetic_unit: rational add/sub/mul/div/compare/normalize/truncate
// with gcd reduction; depends on rau_pkg

// One word is worked at a time. Cross products come from a shift-add
// multiplier that retires one bit per cycle: three products for add and
// sub, two for mul, div and compare. Reduction runs a binary gcd, one step
// per cycle, then two restoring divisions; truncate is one such division
// followed by the same reduction. A finished result sits in the output
// register, so the next word is taken while it waits.
module rational_arithmetic_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_stall,
    input  rau_pkg::op_word_t  op_word,
    output logic               res_valid,
    input  logic               res_stall,
    output rau_pkg::res_word_t res_word
);
    import rau_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] cand;
        logic [NUM_W-1:0] plier;
    } mul_ops_t;

    state_t state_reg, state_next;

    logic [2:0]       func_reg, func_next;
    logic             aneg_reg, aneg_next, bneg_reg, bneg_next;
    logic [NUM_W-1:0] amag_reg, amag_next, bmag_reg, bmag_next;
    logic [NUM_W-1:0] ad_reg, ad_next, bd_reg, bd_next;

    logic [NUM_W-1:0] cand_reg, cand_next, plier_reg, plier_next, acc_reg, acc_next;
    logic [1:0]       mul_idx_reg, mul_idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] p_hi_reg [3];
    logic [NUM_W-1:0] p_lo_reg [3];

    logic             rneg_reg, rneg_next;
    logic [NUM_W-1:0] rmag_reg, rmag_next, rden_reg, rden_next;
    logic [2:0]       flags_reg, flags_next;
    logic [1:0]       err_reg, err_next;

    logic [NUM_W-1:0] u_reg, u_next, v_reg, v_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [NUM_W-1:0] dq_reg, dq_next, dv_reg, dv_next, rem_reg, rem_next;
    logic [1:0]       dmode_reg, dmode_next;

    logic      res_valid_reg, res_valid_next;
    res_word_t res_word_reg, res_word_next;

    // input decode
    logic [NUM_W-1:0] in_araw, in_braw, in_amag, in_bmag, in_ad, in_bd;
    logic             in_aneg, in_bneg, in_uses_b;
    mul_ops_t         ops_start, ops_chain;

    // datapath
    logic [NUM_W:0]   mul_sum;
    logic             mul_last;
    logic [NUM_W:0]   div_rs, div_rn;
    logic             div_ge;
    logic             p0nz, p1nz, s1, s2, lt, eq;
    logic [NUM_W:0]   addsum;
    logic             ev_ovf, ev_neg;
    logic [NUM_W-1:0] ev_mag, ev_den;
    logic [2:0]       ev_flags;
    logic [NUM_W-1:0] fin_lim, out_mag;

    function automatic mul_ops_t mul_ops(input logic [2:0] fn, input logic [1:0] idx,
                                         input logic [NUM_W-1:0] am,
                                         input logic [NUM_W-1:0] bm,
                                         input logic [NUM_W-1:0] ad,
                                         input logic [NUM_W-1:0] bd);
        mul_ops_t r;
        r.cand  = ad;
        r.plier = bd;
        if (idx == 2'd0) begin
            r.cand  = am;
            r.plier = (fn == FN_MUL) ? bm : bd;
        end else if (idx == 2'd1 && fn != FN_MUL) begin
            r.cand  = ad;
            r.plier = bm;
        end
        return r;
    endfunction

    assign in_araw   = op_word.a_num;
    assign in_braw   = op_word.b_num;
    assign in_aneg   = in_araw[NUM_W-1];
    assign in_bneg   = in_braw[NUM_W-1];
    assign in_amag   = in_aneg ? (~in_araw + NUM_W'(1)) : in_araw;
    assign in_bmag   = in_bneg ? (~in_braw + NUM_W'(1)) : in_braw;
    assign in_ad     = {1'b0, op_word.a_den};
    assign in_bd     = {1'b0, op_word.b_den};
    assign in_uses_b = (op_word.func <= FN_CMP);
    assign ops_start = mul_ops(op_word.func, 2'd0, in_amag, in_bmag, in_ad, in_bd);
    assign ops_chain = mul_ops(func_reg, mul_idx_reg + 2'd1, amag_reg, bmag_reg,
                               ad_reg, bd_reg);

    assign mul_sum  = {1'b0, acc_reg} + (plier_reg[0] ? {1'b0, cand_reg} : '0);
    assign mul_last = (cnt_reg == CNT_W'(NUM_W - 1));

    assign div_rs = {rem_reg, dq_reg[NUM_W-1]};
    assign div_ge = (div_rs >= {1'b0, dv_reg});
    assign div_rn = div_ge ? (div_rs - {1'b0, dv_reg}) : div_rs;

    // evaluation of the products, or of operand a for normalize and of the quotient for truncate
    always_comb
    begin
        p0nz     = (p_hi_reg[0] != '0) || (p_lo_reg[0] != '0);
        p1nz     = (p_hi_reg[1] != '0) || (p_lo_reg[1] != '0);
        lt       = {p_hi_reg[0], p_lo_reg[0]} < {p_hi_reg[1], p_lo_reg[1]};
        eq       = {p_hi_reg[0], p_lo_reg[0]} == {p_hi_reg[1], p_lo_reg[1]};
        s1       = aneg_reg && p0nz;
        s2       = bneg_reg && p1nz;
        addsum   = '0;
        ev_ovf   = 1'b0;
        ev_neg   = 1'b0;
        ev_mag   = '0;
        ev_den   = NUM_W'(1);
        ev_flags = 3'b000;
        unique case (func_reg)
            FN_CMP:
            begin
                if (s1 != s2)
                    ev_flags = s1 ? 3'b100 : 3'b001;
                else if (eq)
                    ev_flags = 3'b010;
                else if (s1)
                    ev_flags = lt ? 3'b001 : 3'b100;
                else
                    ev_flags = lt ? 3'b100 : 3'b001;
            end
            FN_ADD, FN_SUB:
            begin
                ev_ovf = !fits(s1, p_hi_reg[0], p_lo_reg[0])
                      || !fits(s2, p_hi_reg[1], p_lo_reg[1])
                      || (p_hi_reg[2] != '0) || (p_lo_reg[2] > MAXPOS);
                if (func_reg == FN_SUB && p_lo_reg[1] != '0)
                    s2 = !s2;
                ev_den = p_lo_reg[2];
                if (s1 == s2) begin
                    addsum = {1'b0, p_lo_reg[0]} + {1'b0, p_lo_reg[1]};
                    ev_mag = addsum[NUM_W-1:0];
                    ev_neg = s1;
                    if (addsum[NUM_W])
                        ev_ovf = 1'b1;
                end else if (p_lo_reg[0] >= p_lo_reg[1]) begin
                    ev_mag = p_lo_reg[0] - p_lo_reg[1];
                    ev_neg = s1;
                end else begin
                    ev_mag = p_lo_reg[1] - p_lo_reg[0];
                    ev_neg = s2;
                end
            end
            FN_MUL:
            begin
                ev_neg = (aneg_reg != bneg_reg) && p0nz;
                ev_mag = p_lo_reg[0];
                ev_den = p_lo_reg[1];
                ev_ovf = !fits(ev_neg, p_hi_reg[0], p_lo_reg[0])
                      || (p_hi_reg[1] != '0) || (p_lo_reg[1] > MAXPOS);
            end
            FN_DIV:
            begin
                ev_mag = p_lo_reg[0];
                ev_neg = (s1 != bneg_reg) && (p_lo_reg[0] != '0);
                ev_den = p_lo_reg[1];
                ev_ovf = !fits(s1, p_hi_reg[0], p_lo_reg[0])
                      || (p_hi_reg[1] != '0) || (p_lo_reg[1] > MAXPOS);
            end
            FN_NORM:
            begin
                ev_mag = amag_reg;
                ev_neg = aneg_reg;
                ev_den = ad_reg;
                ev_ovf = (ad_reg > MAXPOS);
            end
            FN_TRUNC:
            begin
                ev_mag = rmag_reg;
                ev_neg = aneg_reg && (rmag_reg != '0);
            end
            default:
            begin
                ev_mag = '0;
            end
        endcase
    end

    assign fin_lim = MAXPOS + NUM_W'(rneg_reg);
    assign out_mag = rneg_reg ? (~rmag_reg + NUM_W'(1)) : rmag_reg;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        aneg_next      = aneg_reg;
        bneg_next      = bneg_reg;
        amag_next      = amag_reg;
        bmag_next      = bmag_reg;
        ad_next        = ad_reg;
        bd_next        = bd_reg;
        cand_next      = cand_reg;
        plier_next     = plier_reg;
        acc_next       = acc_reg;
        mul_idx_next   = mul_idx_reg;
        cnt_next       = cnt_reg;
        rneg_next      = rneg_reg;
        rmag_next      = rmag_reg;
        rden_next      = rden_reg;
        flags_next     = flags_reg;
        err_next       = err_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        dq_next        = dq_reg;
        dv_next        = dv_reg;
        rem_next       = rem_reg;
        dmode_next     = dmode_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_word_next  = res_word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid) begin
                    func_next    = op_word.func;
                    aneg_next    = in_aneg;
                    bneg_next    = in_bneg;
                    amag_next    = in_amag;
                    bmag_next    = in_bmag;
                    ad_next      = in_ad;
                    bd_next      = in_bd;
                    rneg_next    = 1'b0;
                    rmag_next    = '0;
                    rden_next    = NUM_W'(1);
                    flags_next   = 3'b000;
                    err_next     = ERR_OK;
                    cand_next    = ops_start.cand;
                    plier_next   = ops_start.plier;
                    acc_next     = '0;
                    mul_idx_next = 2'd0;
                    cnt_next     = '0;
                    dq_next      = in_amag;
                    dv_next      = in_ad;
                    rem_next     = '0;
                    dmode_next   = DM_TRUNC;
                    if (op_word.func == FN_NONE)
                        state_next = ST_DONE;
                    else if (in_ad == '0 || (in_uses_b && in_bd == '0)) begin
                        err_next   = ERR_ZERODEN;
                        state_next = ST_DONE;
                    end else if (op_word.func == FN_DIV && in_bmag == '0) begin
                        err_next   = ERR_DIVZERO;
                        state_next = ST_DONE;
                    end else if (op_word.func == FN_CMP)
                        state_next = ST_MUL;
                    else if (!fits(in_aneg, '0, in_amag) || in_ad > MAXPOS
                             || (in_uses_b && (!fits(in_bneg, '0, in_bmag)
                                               || in_bd > MAXPOS))) begin
                        err_next   = ERR_OVF;
                        state_next = ST_DONE;
                    end else if (op_word.func == FN_NORM)
                        state_next = ST_EVAL;
                    else if (op_word.func == FN_TRUNC)
                        state_next = ST_DIV;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next   = mul_sum[NUM_W:1];
                plier_next = {mul_sum[0], plier_reg[NUM_W-1:1]};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (mul_last) begin
                    if ((func_reg == FN_ADD || func_reg == FN_SUB) ? (mul_idx_reg == 2'd2)
                                                                   : (mul_idx_reg == 2'd1))
                        state_next = ST_EVAL;
                    else begin
                        mul_idx_next = mul_idx_reg + 2'd1;
                        cand_next    = ops_chain.cand;
                        plier_next   = ops_chain.plier;
                        acc_next     = '0;
                    end
                end
            end
            ST_EVAL:
            begin
                flags_next = ev_flags;
                rneg_next  = ev_neg;
                rmag_next  = ev_mag;
                rden_next  = ev_den;
                u_next     = ev_mag;
                v_next     = ev_den;
                k_next     = '0;
                if (func_reg == FN_CMP) begin
                    rneg_next  = 1'b0;
                    rmag_next  = '0;
                    rden_next  = NUM_W'(1);
                    state_next = ST_DONE;
                end else if (ev_ovf) begin
                    err_next   = ERR_OVF;
                    state_next = ST_DONE;
                end else if (ev_mag == '0) begin
                    rneg_next  = 1'b0;
                    rden_next  = NUM_W'(1);
                    state_next = ST_FIN;
                end else
                    state_next = ST_GCD;
            end
            ST_GCD:
            begin
                priority if (u_reg == v_reg) begin
                    dq_next    = rmag_reg;
                    dv_next    = u_reg << k_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    dmode_next = DM_NUM;
                    state_next = ST_DIV;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + CNT_W'(1);
                end else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (u_reg > v_reg)
                    u_next = (u_reg - v_reg) >> 1;
                else
                    v_next = (v_reg - u_reg) >> 1;
            end
            ST_DIV:
            begin
                rem_next = div_rn[NUM_W-1:0];
                dq_next  = {dq_reg[NUM_W-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (mul_last) begin
                    unique case (dmode_reg)
                        DM_TRUNC:
                        begin
                            rmag_next  = {dq_reg[NUM_W-2:0], div_ge};
                            state_next = ST_EVAL;
                        end
                        DM_NUM:
                        begin
                            rmag_next  = {dq_reg[NUM_W-2:0], div_ge};
                            dq_next    = rden_reg;
                            rem_next   = '0;
                            dmode_next = DM_DEN;
                        end
                        default:
                        begin
                            rden_next  = {dq_reg[NUM_W-2:0], div_ge};
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_FIN:
            begin
                if (rmag_reg > fin_lim)
                    err_next = ERR_OVF;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall) begin
                    res_valid_next = 1'b1;
                    if (err_reg != ERR_OK) begin
                        res_word_next.res_num    = '0;
                        res_word_next.res_den    = DEN_W'(1);
                        res_word_next.is_less    = 1'b0;
                        res_word_next.is_equal   = 1'b0;
                        res_word_next.is_greater = 1'b0;
                    end else begin
                        res_word_next.res_num    = out_mag;
                        res_word_next.res_den    = rden_reg[DEN_W-1:0];
                        res_word_next.is_less    = flags_reg[2];
                        res_word_next.is_equal   = flags_reg[1];
                        res_word_next.is_greater = flags_reg[0];
                    end
                    res_word_next.error_code = err_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        aneg_reg     <= aneg_next;
        bneg_reg     <= bneg_next;
        amag_reg     <= amag_next;
        bmag_reg     <= bmag_next;
        ad_reg       <= ad_next;
        bd_reg       <= bd_next;
        cand_reg     <= cand_next;
        plier_reg    <= plier_next;
        acc_reg      <= acc_next;
        mul_idx_reg  <= mul_idx_next;
        cnt_reg      <= cnt_next;
        rneg_reg     <= rneg_next;
        rmag_reg     <= rmag_next;
        rden_reg     <= rden_next;
        flags_reg    <= flags_next;
        err_reg      <= err_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        k_reg        <= k_next;
        dq_reg       <= dq_next;
        dv_reg       <= dv_next;
        rem_reg      <= rem_next;
        dmode_reg    <= dmode_next;
        res_word_reg <= res_word_next;
        if (state_reg == ST_MUL && mul_last) begin
            p_hi_reg[mul_idx_reg] <= mul_sum[NUM_W:1];
            p_lo_reg[mul_idx_reg] <= {mul_sum[0], plier_reg[NUM_W-1:1]};
        end
    end

    assign op_stall  = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // error words carry a clean result
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.error_code != ERR_OK |->
            res_word.res_num == '0 && res_word.res_den == DEN_W'(1)
            && !res_word.is_less && !res_word.is_equal && !res_word.is_greater)
        else $error("error word with nonzero result");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0({res_word.is_less, res_word.is_equal, res_word.is_greater}))
        else $error("more than one compare flag");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_word.res_den != '0)
        else $error("zero denominator delivered");

    a_gcd_nz: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GCD |-> u_reg != '0 && v_reg != '0)
        else $error("gcd operand reached zero");

    a_new_word: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_stall |=> state_reg != ST_IDLE)
        else $error("accepted word left no work");

endmodule

@@ dv/rau_checker.sv @@
// rau_checker: watches both channels of the rational arithmetic unit, predicts
// each result word and compares it field by field; depends on rau_pkg

module rau_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  logic               op_stall,
    input  rau_pkg::op_word_t  op_word,
    input  logic               res_valid,
    input  logic               res_stall,
    input  rau_pkg::res_word_t res_word,
    output int                 fail_count,
    output int                 pending
);
    import rau_pkg::*;

    res_word_t expected_q[$];

    // product lies in the signed 64-bit range
    function automatic logic fits_word(input logic signed [127:0] p);
        fits_word = (p[127:63] == '0) || (p[127:63] == '1);
    endfunction

    function automatic logic [127:0] magnitude(input logic signed [127:0] p);
        magnitude = p[127] ? -p : p;
    endfunction

    function automatic res_word_t rational_result(input op_word_t w);
        res_word_t        r;
        logic signed [127:0] a, b, ad, bd, p1, p2, s;
        logic [127:0]     mag, den;
        logic [63:0]      x, y, t;
        logic             neg, ovf, uses_b;
        r            = '0;
        r.res_den    = 63'd1;
        r.error_code = ERR_OK;
        if (w.func == FN_NONE)
            return r;
        uses_b = (w.func <= FN_CMP);
        if (w.a_den == 0 || (uses_b && w.b_den == 0))
        begin
            r.error_code = ERR_ZERODEN;
            return r;
        end
        if (w.func == FN_DIV && w.b_num == 0)
        begin
            r.error_code = ERR_DIVZERO;
            return r;
        end
        a  = $signed({{64{w.a_num[63]}}, w.a_num});
        b  = $signed({{64{w.b_num[63]}}, w.b_num});
        ad = $signed({65'b0, w.a_den});
        bd = $signed({65'b0, w.b_den});
        if (w.func == FN_CMP)
        begin
            p1 = a * bd;
            p2 = b * ad;
            r.is_less    = p1 < p2;
            r.is_equal   = p1 == p2;
            r.is_greater = p1 > p2;
            return r;
        end
        ovf = 1'b0;
        neg = 1'b0;
        mag = '0;
        den = 128'd1;
        case (w.func)
            FN_ADD, FN_SUB:
            begin
                p1  = a * bd;
                p2  = b * ad;
                den = ad * bd;
                if (!fits_word(p1) || !fits_word(p2))
                    ovf = 1'b1;
                else
                begin
                    s   = (w.func == FN_SUB) ? p1 - p2 : p1 + p2;
                    neg = s[127];
                    mag = magnitude(s);
                    if (mag[127:64] != 0)
                        ovf = 1'b1;
                end
            end
            FN_MUL:
            begin
                p1  = a * b;
                den = ad * bd;
                ovf = !fits_word(p1);
                neg = p1[127];
                mag = magnitude(p1);
            end
            FN_DIV:
            begin
                p1  = a * bd;
                den = ad * magnitude(b);
                ovf = !fits_word(p1);
                mag = magnitude(p1);
                neg = (p1[127] != b[127]) && mag != 0;
            end
            FN_NORM:
            begin
                neg = a[127];
                mag = magnitude(a);
                den = ad;
            end
            default:
            begin
                mag = magnitude(a) / ad;
                neg = a[127] && mag != 0;
                den = 128'd1;
            end
        endcase
        if (den[127:63] != 0)
            ovf = 1'b1;
        if (!ovf)
        begin
            if (mag == 0)
            begin
                neg = 1'b0;
                den = 128'd1;
            end
            else
            begin
                x = mag[63:0];
                y = den[63:0];
                while (y != 0)
                begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                mag = mag / x;
                den = den / x;
            end
            if (mag > ({64'b0, MAXPOS} + neg))
                ovf = 1'b1;
        end
        if (ovf)
        begin
            r.error_code = ERR_OVF;
            return r;
        end
        r.res_num = neg ? -mag[63:0] : mag[63:0];
        r.res_den = den[62:0];
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result word: num %0d den %0d err %0d",
                           res_word.res_num, res_word.res_den, res_word.error_code);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res_word.res_num !== want.res_num)
                    begin
                        $error("res_num: expected %0d, got %0d", want.res_num, res_word.res_num);
                        fail_count++;
                    end
                    if (res_word.res_den !== want.res_den)
                    begin
                        $error("res_den: expected %0d, got %0d", want.res_den, res_word.res_den);
                        fail_count++;
                    end
                    if (res_word.is_less !== want.is_less)
                    begin
                        $error("is_less: expected %0b, got %0b", want.is_less, res_word.is_less);
                        fail_count++;
                    end
                    if (res_word.is_equal !== want.is_equal)
                    begin
                        $error("is_equal: expected %0b, got %0b", want.is_equal,
                               res_word.is_equal);
                        fail_count++;
                    end
                    if (res_word.is_greater !== want.is_greater)
                    begin
                        $error("is_greater: expected %0b, got %0b", want.is_greater,
                               res_word.is_greater);
                        fail_count++;
                    end
                    if (res_word.error_code !== want.error_code)
                    begin
                        $error("error_code: expected %0d, got %0d", want.error_code,
                               res_word.error_code);
                        fail_count++;
                    end
                end
            end
            if (op_valid && !op_stall)
                expected_q.push_back(rational_result(op_word));
            pending = expected_q.size();
        end
    end

endmodule

@@ dv/tb_rational_arithmetic_unit.sv @@
// tb_rational_arithmetic_unit: directed and random words for the rational
// arithmetic unit with random idling; depends on rau_pkg, rational_arithmetic_unit and rau_checker

module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_WORDS = 450;

    logic      clk;
    logic      rst_n;
    logic      op_valid;
    logic      op_stall;
    op_word_t  op_word;
    logic      res_valid;
    logic      res_stall;
    res_word_t res_word;
    int        fail_count;
    int        pending;
    logic      steady;
    logic      long_hold;
    int        idle_cycles;

    rational_arithmetic_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_stall (op_stall),
        .op_word  (op_word),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_word (res_word)
    );

    rau_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_word   (op_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] pick_num();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 4)
            return 64'($signed($urandom_range(0, 2000)) - 1000);
        if (sel <= 6)
            return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom())};
        if (sel == 7)
            return {32'($urandom()), 32'($urandom())};
        if (sel == 8)
        begin
            case ($urandom_range(0, 4))
                0: return 64'h8000_0000_0000_0000;
                1: return 64'h7fff_ffff_ffff_ffff;
                2: return 64'd0;
                3: return '1;
                default: return 64'd1;
            endcase
        end
        return ($urandom_range(0, 1) == 1) ? -(64'd1 << $urandom_range(0, 63))
                                           : (64'd1 << $urandom_range(0, 62));
    endfunction

    function automatic logic [62:0] pick_den();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel <= 12)
            return 63'($urandom_range(1, 1000));
        if (sel <= 15)
            return 63'($urandom());
        if (sel <= 18)
            return {31'($urandom()), 32'($urandom())};
        return '1;
    endfunction

    function automatic op_word_t make_word(logic [2:0] f, logic [63:0] an, logic [62:0] ad,
                                           logic [63:0] bn, logic [62:0] bd);
        op_word_t w;
        w.func  = f;
        w.a_num = an;
        w.a_den = ad;
        w.b_num = bn;
        w.b_den = bd;
        return w;
    endfunction

    // offer one word after a random gap, return at the edge that takes it
    task automatic send_word(input op_word_t w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            op_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_valid <= 1'b1;
        op_word  <= w;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
    endtask

    // result side
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 8);
            if (long_hold)
            begin
                hold      = 2000;
                long_hold = 1'b0;
            end
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                res_stall <= 1'b0;
            end
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    // watchdog on cycles without any accepted word
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((op_valid && !op_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

    initial
    begin
        op_word_t w;
        logic [2:0] f;
        op_valid  = 1'b0;
        op_word   = '0;
        res_stall = 1'b0;
        steady    = 1'b0;
        long_hold = 1'b0;
        rst_n     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(FN_ADD, 64'd1, 63'd2, 64'd1, 63'd3));
        send_word(make_word(FN_SUB, 64'd1, 63'd2, 64'd3, 63'd4));
        send_word(make_word(FN_MUL, -64'd6, 63'd5, 64'd10, 63'd9));
        send_word(make_word(FN_DIV, 64'd3, 63'd4, -64'd9, 63'd8));
        send_word(make_word(FN_CMP, 64'd1, 63'd3, 64'd1, 63'd2));
        send_word(make_word(FN_CMP, 64'd2, 63'd4, 64'd1, 63'd2));
        send_word(make_word(FN_CMP, 64'h7fff_ffff_ffff_ffff, 63'd1,
                            64'h8000_0000_0000_0000, '1));
        send_word(make_word(FN_NORM, 64'd6, 63'd4, 64'd0, 63'd0));
        send_word(make_word(FN_NORM, 64'd0, 63'd5, 64'd0, 63'd0));
        send_word(make_word(FN_NORM, 64'h8000_0000_0000_0000, 63'd1, 64'd0, 63'd0));
        send_word(make_word(FN_TRUNC, -64'd7, 63'd2, 64'd0, 63'd0));
        send_word(make_word(FN_TRUNC, 64'h8000_0000_0000_0000, 63'd1, 64'd5, 63'd0));
        send_word(make_word(FN_ADD, 64'd1, 63'd0, 64'd1, 63'd1));
        send_word(make_word(FN_ADD, 64'd1, 63'd1, 64'd1, 63'd0));
        send_word(make_word(FN_DIV, 64'd1, 63'd2, 64'd0, 63'd3));
        send_word(make_word(FN_ADD, 64'h7fff_ffff_ffff_ffff, 63'd1,
                            64'h7fff_ffff_ffff_ffff, 63'd1));
        send_word(make_word(FN_ADD, 64'h8000_0000_0000_0000, 63'd1,
                            64'h8000_0000_0000_0000, 63'd1));
        send_word(make_word(FN_MUL, 64'h8000_0000_0000_0000, 63'd1, '1, 63'd1));
        send_word(make_word(FN_ADD, 64'd1, '1, 64'd1, '1));
        send_word(make_word(FN_SUB, 64'd0, 63'd1, 64'h8000_0000_0000_0000, 63'd1));
        send_word(make_word(FN_DIV, 64'h8000_0000_0000_0000, 63'd1, '1, 63'd1));
        send_word(make_word(FN_NONE, '1, '0, '1, '0));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 60 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if (i == 150)
                long_hold = 1'b1;
            if (i == 300)
            begin
                op_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                repeat (600) @(posedge clk);
            end
            f = ($urandom_range(0, 20) == 0) ? FN_NONE : 3'($urandom_range(0, 6));
            w = make_word(f, pick_num(), pick_den(), pick_num(), pick_den());
            send_word(w);
        end
        op_valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[rational_arithmetic_unit] OK");
        else
            $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

endmodule
